### hdl/free_list_block_allocator_assert.svh
// Assertion macros for the free-list block allocator, clocked on clk and disabled in reset.
`ifndef FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define FLBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define FLBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FLBA_ASSERT_NOW(lbl, ante, cons, msg)
`define FLBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hdl/flba_pkg.sv
// Shared types and constants of the free-list block allocator.
package flba_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  // Block count after reset, before saturation to the pool depth.
  localparam int CNT_RESET = 64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] free_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] block_index;
    logic [ST_W-1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic sweep;
    logic accept;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic slot_free;
  } dp_sts_t;

endpackage

### hdl/flba_ctrl.sv
// Controller of the free-list block allocator: init sweep, accept and commit sequencing.
module flba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_fire,
  input  logic               in_valid,
  output logic               in_ready,
  input  flba_pkg::dp_sts_t  sts,
  output flba_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    INIT,
    IDLE,
    EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd.sweep  = (state_r == INIT);
    cmd.accept = in_valid && in_ready_r;
    cmd.commit = (state_r == EXEC) && sts.slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      INIT: begin
        if (sts.sweep_last) begin
          state_nxt = IDLE;
        end
      end
      IDLE: begin
        if (cmd.accept) begin
          state_nxt = EXEC;
        end
      end
      EXEC: begin
        if (cmd.commit) begin
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = INIT;
      end
    endcase
    // A count write always rebuilds the chain from the start.
    if (cfg_fire) begin
      state_nxt = INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= INIT;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

### hdl/flba_dpath.sv
// Datapath of the free-list block allocator: link memory, head, count and result register.
module flba_dpath #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  flba_pkg::ctl_cmd_t         cmd,
  output flba_pkg::dp_sts_t          sts,
  input  logic                       cfg_fire,
  input  logic [flba_pkg::CNT_W-1:0] cfg_data,
  input  flba_pkg::req_t             in_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output flba_pkg::rsp_t             out_rsp
);

  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CMP_W  = (LINK_W > flba_pkg::CNT_W) ? LINK_W : flba_pkg::CNT_W;
  localparam int RST_CNT = (POOL_DEPTH < flba_pkg::CNT_RESET) ? POOL_DEPTH
                                                               : flba_pkg::CNT_RESET;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);
  localparam logic [LINK_W-1:0] LAST_IDX  = LINK_W'(POOL_DEPTH - 1);
  localparam logic [LINK_W-1:0] RST_COUNT = LINK_W'(RST_CNT);

  logic [LINK_W-1:0]  link_mem [POOL_DEPTH];
  logic [LINK_W-1:0]  rd_link_r;
  logic [LINK_W-1:0]  head_r;
  logic [LINK_W-1:0]  head_nxt;
  logic [LINK_W-1:0]  count_r;
  logic [LINK_W-1:0]  sweep_r;
  flba_pkg::req_t     req_r;
  logic               out_valid_r;
  flba_pkg::rsp_t     out_rsp_r;
  flba_pkg::rsp_t     rsp;

  logic [LINK_W-1:0]  cfg_sat;
  logic [LINK_W-1:0]  sweep_succ;
  logic [LINK_W-1:0]  sweep_link;
  logic               head_null;
  logic               idx_in_range;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [LINK_W-1:0]  wr_data;
  logic [ADDR_W-1:0]  head_addr;

  assign cfg_sat = (CMP_W'(cfg_data) > CMP_W'(POOL_DEPTH)) ? NULL_LINK
                                                          : LINK_W'(cfg_data);

  // During the sweep entry i links to i+1, and the last entry in use to null.
  assign sweep_succ = sweep_r + LINK_W'(1);
  assign sweep_link = (sweep_succ < count_r) ? sweep_succ : NULL_LINK;

  assign head_null    = (head_r >= NULL_LINK);
  assign head_addr    = head_r[ADDR_W-1:0];
  assign idx_in_range = (CMP_W'(req_r.free_index) < CMP_W'(count_r));

  assign sts.sweep_last = (sweep_r == LAST_IDX);
  assign sts.slot_free  = !out_valid_r || out_ready;

  always_comb begin
    rsp.block_index = '0;
    rsp.status      = flba_pkg::ST_OK;
    head_nxt        = head_r;
    if (req_r.kind == flba_pkg::KIND_ALLOC) begin
      if (head_null) begin
        rsp.status = flba_pkg::ST_EMPTY;
      end else begin
        rsp.block_index = flba_pkg::IDX_W'(head_r);
        head_nxt        = rd_link_r;
      end
    end else begin
      if (idx_in_range) begin
        head_nxt = LINK_W'(req_r.free_index);
      end else begin
        rsp.status = flba_pkg::ST_RANGE;
      end
    end
  end

  always_comb begin
    wr_en   = cmd.sweep ||
              (cmd.commit && (req_r.kind == flba_pkg::KIND_FREE) && idx_in_range);
    wr_addr = cmd.sweep ? sweep_r[ADDR_W-1:0] : ADDR_W'(req_r.free_index);
    wr_data = cmd.sweep ? sweep_link : head_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    // The link of the head is fetched as the item is taken, ready for the commit.
    if (cmd.accept && !head_null) begin
      rd_link_r <= link_mem[head_addr];
    end
    if (cmd.accept) begin
      req_r <= in_req;
    end
    if (cmd.commit) begin
      out_rsp_r <= rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= RST_COUNT;
      sweep_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        count_r <= cfg_sat;
        sweep_r <= '0;
      end else if (cmd.sweep) begin
        sweep_r <= sweep_succ;
      end
      if (cmd.sweep && sts.sweep_last) begin
        head_r <= (count_r == '0) ? NULL_LINK : '0;
      end else if (cmd.commit) begin
        head_r <= head_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

### hdl/free_list_block_allocator.sv
// Top level of the free-list block allocator: controller, datapath and assertions.
//
// Hands out and takes back pool blocks by index through a LIFO free list held in a
// single-port link memory of POOL_DEPTH entries. Each request item is accepted in
// the idle step, which fetches the link of the current head from the synchronous
// link memory, and committed in the execute step, which sets the new head and loads
// the result register; no new item is accepted until the last one has committed,
// and a stalled result holds the commit until the register frees.
// After reset and after every write of the block count, an initialisation pass over
// all POOL_DEPTH entries rebuilds the chain 0 -> 1 -> ... -> count-1 one entry a cycle,
// and no request item is accepted during it. The configuration port is always ready.
`include "free_list_block_allocator_assert.svh"

module free_list_block_allocator #(
  parameter int POOL_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [flba_pkg::CNT_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  flba_pkg::req_t             in_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output flba_pkg::rsp_t             out_rsp
);

  flba_pkg::ctl_cmd_t cmd;
  flba_pkg::dp_sts_t  sts;
  logic               cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  flba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_fire (cfg_fire),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  flba_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_fire  (cfg_fire),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // One item at a time: taking an item closes the input until its result is committed.
  `FLBA_ASSERT_NEXT(a_accept_closes, in_valid && in_ready, !in_ready, "input open after accept")
  // A count write starts the rebuild, during which no item may enter.
  `FLBA_ASSERT_NEXT(a_cfg_rebuilds, cfg_valid && cfg_ready, !in_ready, "input open after cfg")
  // A new result is only committed out of the execute step, never straight from idle.
  `FLBA_ASSERT_NOW(a_result_after_exec, $rose(out_valid), !$past(in_ready), "result without exec")
  `FLBA_ASSERT_NOW(a_status_legal, out_valid, (out_rsp.status == flba_pkg::ST_OK) || (out_rsp.status == flba_pkg::ST_EMPTY) || (out_rsp.status == flba_pkg::ST_RANGE), "illegal status code")

endmodule

### tb/free_list_block_allocator_tb.sv
// Self-checking testbench for the free-list block allocator, with a LIFO pool model and random traffic.
`timescale 1ns / 1ps

module free_list_block_allocator_tb;

  localparam int DEPTH = 64;
  localparam logic [flba_pkg::CNT_W-1:0] NULL_LINK = flba_pkg::CNT_W'(DEPTH);
  localparam int PHASE_ITEMS = 260;

  // Mirrors the pool: the link table, the head and the blocks handed out so far.
  class alloc_ledger;
    logic [flba_pkg::CNT_W-1:0] link [DEPTH];
    logic [flba_pkg::CNT_W-1:0] head;
    logic [flba_pkg::CNT_W-1:0] count;
    flba_pkg::rsp_t             due_rsp [$];
    logic [flba_pkg::IDX_W-1:0] held [$];
    int                         errors;

    function void flag(string msg);
      if (errors < 10) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
    endfunction

    function void set_count(logic [flba_pkg::CNT_W-1:0] value);
      count = (value > DEPTH) ? NULL_LINK : value;
      for (int i = 0; i < DEPTH; i++) link[i] = NULL_LINK;
      held.delete();
      if (count == 0) begin
        head = NULL_LINK;
      end else begin
        for (int i = 0; i + 1 < count; i++) link[i] = flba_pkg::CNT_W'(i + 1);
        head = '0;
      end
    endfunction

    function void log_request(flba_pkg::req_t req);
      flba_pkg::rsp_t rsp;
      int             pos;
      rsp = '0;
      pos = -1;
      if (req.kind == flba_pkg::KIND_ALLOC) begin
        if (head >= NULL_LINK) begin
          rsp.status = flba_pkg::ST_EMPTY;
        end else begin
          rsp.block_index = head[flba_pkg::IDX_W-1:0];
          rsp.status      = flba_pkg::ST_OK;
          held.push_back(head[flba_pkg::IDX_W-1:0]);
          head = link[head[flba_pkg::IDX_W-1:0]];
        end
      end else if (flba_pkg::CNT_W'(req.free_index) >= count) begin
        rsp.status = flba_pkg::ST_RANGE;
      end else begin
        link[req.free_index] = head;
        head = {1'b0, req.free_index};
        rsp.status = flba_pkg::ST_OK;
        foreach (held[k]) if (pos < 0 && held[k] == req.free_index) pos = k;
        if (pos >= 0) held.delete(pos);
      end
      due_rsp.push_back(rsp);
    endfunction

    function void match_response(flba_pkg::rsp_t got);
      flba_pkg::rsp_t want;
      if (due_rsp.size() == 0) begin
        flag($sformatf("unexpected result: block_index %0d status %0d",
                       got.block_index, got.status));
        return;
      end
      want = due_rsp.pop_front();
      if (got.block_index !== want.block_index) begin
        flag($sformatf("block_index expected %0d actual %0d", want.block_index,
                       got.block_index));
      end
      if (got.status !== want.status) begin
        flag($sformatf("status expected %0d actual %0d", want.status, got.status));
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [flba_pkg::CNT_W-1:0] cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  flba_pkg::req_t             in_req = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  flba_pkg::rsp_t             out_rsp;

  int          sender_idle = 0;
  int          recv_stall = 0;
  alloc_ledger ledger;

  int phase_idle  [4] = '{0, 56, 0, 34};
  int phase_stall [4] = '{0, 0, 56, 34};

  free_list_block_allocator #(.POOL_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.match_response(out_rsp);
  end

  function automatic flba_pkg::req_t make_req(logic kind,
                                              logic [flba_pkg::IDX_W-1:0] idx);
    flba_pkg::req_t req;
    req.kind       = kind;
    req.free_index = idx;
    return req;
  endfunction

  // Mostly balanced allocate and free traffic on blocks actually held; the rest is
  // noise that brings in stray frees, double frees and allocates from an empty pool.
  function automatic flba_pkg::req_t pick_request();
    flba_pkg::req_t req;
    int             roll;
    roll = $urandom_range(0, 99);
    req  = '0;
    if (roll < 12) begin
      req.kind       = 1'($urandom_range(0, 1));
      req.free_index = flba_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
    end else if (ledger.held.size() > 0 &&
                 (ledger.held.size() >= ledger.count || $urandom_range(0, 99) < 45)) begin
      req.kind       = flba_pkg::KIND_FREE;
      req.free_index = ledger.held[$urandom_range(0, ledger.held.size() - 1)];
    end else begin
      req.kind       = flba_pkg::KIND_ALLOC;
      req.free_index = flba_pkg::IDX_W'($urandom_range(0, DEPTH - 1));
    end
    return req;
  endfunction

  task automatic send_request(input flba_pkg::req_t req);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    ledger.log_request(req);
  endtask

  task automatic settle_pool();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (ledger.due_rsp.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (ledger.due_rsp.size() != 0) begin
      ledger.flag($sformatf("%0d results never arrived", ledger.due_rsp.size()));
      ledger.due_rsp.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [flba_pkg::CNT_W-1:0] value);
    settle_pool();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ledger.set_count(value);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL free_list_block_allocator");
    $finish;
  end

  initial begin
    ledger = new();
    ledger.set_count(flba_pkg::CNT_W'(flba_pkg::CNT_RESET));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Full pool straight after reset, including a free of a block never handed out.
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd63));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd1));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));

    // A single block: the pool empties, stray frees are refused, and a double free loops.
    write_count(7'd1);
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd1));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd63));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));

    // A count of zero leaves the pool empty.
    write_count(7'd0);
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_FREE, 6'd0));

    // The largest count saturates to the pool depth; the index of an allocate is ignored.
    write_count(7'd127);
    send_request(make_req(flba_pkg::KIND_FREE, 6'd63));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, '0));
    send_request(make_req(flba_pkg::KIND_ALLOC, 6'd63));

    for (int p = 0; p < 4; p++) begin
      sender_idle = phase_idle[p];
      recv_stall  = phase_stall[p];
      case (p)
        0: write_count(7'd64);
        1: write_count(7'd8);
        2: write_count(7'd1);
        default: write_count(flba_pkg::CNT_W'($urandom_range(2, DEPTH - 1)));
      endcase
      repeat (PHASE_ITEMS) send_request(pick_request());
    end

    settle_pool();
    if (ledger.errors == 0) begin
      $display("PASS free_list_block_allocator");
    end else begin
      $display("FAIL free_list_block_allocator");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/flba_pkg.sv
hdl/flba_ctrl.sv
hdl/flba_dpath.sv
hdl/free_list_block_allocator.sv
tb/free_list_block_allocator_tb.sv
